// File: rtl/lzd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzd_pkg: shared types and constants of the lz77 token decoder
// history geometry, beat packing, controller states and the command and
// status groups between the controller and the datapath
// ----------------------------------------------------------------------------
package lzd_pkg;

  // history window
  localparam int HISTORY_DEPTH = 65536;
  localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
  localparam int PROD_W        = HIST_AW + 1;

  // beat packing
  localparam int BYTES_PER_BEAT = 8;
  localparam int DATA_W         = 8 * BYTES_PER_BEAT;
  localparam int COUNT_W        = 4;

  // token fields
  localparam int LCODE_W = 8;
  localparam int DIST_W  = 16;
  localparam int LEN_W   = LCODE_W + 1;
  localparam int MIN_LEN = 3;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_COPY
  } lzd_state_t;

  // controller to datapath
  typedef struct packed {
    logic take_lit;    // literal accepted: store and emit it
    logic take_bad;    // bad match accepted: emit error beat
    logic take_match;  // good match accepted: load copy pointers
    logic copy_en;     // copy loop running
  } lzd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;    // output register can take a beat this cycle
    logic dist_bad;    // current input distance is out of range
    logic copy_done;   // final copied byte packed this cycle
  } lzd_status_t;

endpackage : lzd_pkg
`default_nettype wire

// File: rtl/lzd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzd_ctrl: token controller
// accepts tokens, sorts them into literal, bad match and copy, and holds
// off new tokens while a copy is streaming
// ----------------------------------------------------------------------------
module lzd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_is_match,
  input  wire lzd_pkg::lzd_status_t status,
  output logic                      in_ready,
  output lzd_pkg::lzd_cmd_t         cmd
);
  import lzd_pkg::*;

  lzd_state_t state_r;
  lzd_state_t state_nxt;
  logic       accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_is_match && !status.dist_bad) begin
          state_nxt = ST_COPY;
        end
      end
      ST_COPY: begin
        if (status.copy_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready       = 1'b0;
    cmd.take_lit   = 1'b0;
    cmd.take_bad   = 1'b0;
    cmd.take_match = 1'b0;
    cmd.copy_en    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready       = status.out_free;
        cmd.take_lit   = accept && !in_is_match;
        cmd.take_bad   = accept && in_is_match && status.dist_bad;
        cmd.take_match = accept && in_is_match && !status.dist_bad;
      end
      ST_COPY: begin
        cmd.copy_en = 1'b1;
      end
      default: ;
    endcase
  end

endmodule : lzd_ctrl
`default_nettype wire

// File: rtl/lzd_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzd_datapath: history ram, copy pointers and beat packing
// one byte per cycle, unless the output stalls, is read from history, written
// back at the write pointer and packed into beats held in the output register
// ----------------------------------------------------------------------------
module lzd_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [7:0]                     in_literal_byte,
  input  wire logic [lzd_pkg::LCODE_W-1:0]    in_length_code,
  input  wire logic [lzd_pkg::DIST_W-1:0]     in_distance,
  input  wire lzd_pkg::lzd_cmd_t              cmd,
  output lzd_pkg::lzd_status_t                status,
  input  wire logic                           out_ready,
  output logic                                out_valid,
  output logic [lzd_pkg::DATA_W-1:0]          out_data_bytes,
  output logic [lzd_pkg::COUNT_W-1:0]         out_byte_count,
  output logic                                out_last,
  output logic                                out_bad_distance
);
  import lzd_pkg::*;

  // history store, contents undefined until written
  logic [7:0]         hist_mem [HISTORY_DEPTH];

  logic [HIST_AW-1:0] wp_r;
  logic [PROD_W-1:0]  produced_r;
  logic [HIST_AW-1:0] src_r;
  logic [LEN_W-1:0]   remain_r;

  // read stage
  logic               bv_r;
  logic               blast_r;
  logic [7:0]         rd_q_r;
  logic               hit_r;
  logic [7:0]         fwd_r;

  // packing
  logic [COUNT_W-1:0] fill_r;
  logic [DATA_W-1:0]  word_r;

  // output register
  logic                out_valid_r;
  logic [DATA_W-1:0]   out_data_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic                out_last_r;
  logic                out_bad_r;

  logic                out_free;
  logic                pack_emit;
  logic                adv;
  logic                issue;
  logic                consume;
  logic [7:0]          cur_byte;
  logic                we;
  logic [7:0]          wdata;
  logic [DATA_W-1:0]   pack_word;
  logic                push;
  logic                dist_bad;

  assign out_free  = !out_valid_r || out_ready;
  assign pack_emit = bv_r && ((fill_r == COUNT_W'(BYTES_PER_BEAT - 1)) || blast_r);
  assign adv       = !pack_emit || out_free;
  assign issue     = cmd.copy_en && (remain_r != '0) && adv;
  assign consume   = bv_r && adv;
  assign cur_byte  = hit_r ? fwd_r : rd_q_r;
  assign we        = cmd.take_lit || consume;
  assign wdata     = cmd.take_lit ? in_literal_byte : cur_byte;
  assign push      = cmd.take_lit || cmd.take_bad || (consume && pack_emit);
  assign dist_bad  = (in_distance == '0) || (PROD_W'(in_distance) > produced_r);

  always_comb begin
    pack_word = word_r;
    for (int k = 0; k < BYTES_PER_BEAT; k++) begin
      if (fill_r == COUNT_W'(k)) begin
        pack_word[k*8 +: 8] = cur_byte;
      end
    end
  end

  assign status.out_free  = out_free;
  assign status.dist_bad  = dist_bad;
  assign status.copy_done = consume && blast_r;

  // history ram
  always_ff @(posedge clk) begin
    if (we) begin
      hist_mem[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_q_r <= hist_mem[src_r];
    end
  end

  // read-during-write bypass for distance one
  always_ff @(posedge clk) begin
    if (issue) begin
      hit_r   <= we && (wp_r == src_r);
      fwd_r   <= wdata;
      blast_r <= (remain_r == LEN_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_match) begin
      src_r <= wp_r - in_distance;
    end else if (issue) begin
      src_r <= src_r + HIST_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      produced_r <= '0;
      remain_r   <= '0;
      bv_r       <= 1'b0;
      fill_r     <= '0;
      word_r     <= '0;
    end else begin
      if (we) begin
        wp_r <= wp_r + HIST_AW'(1);
        if (produced_r != PROD_W'(HISTORY_DEPTH)) begin
          produced_r <= produced_r + PROD_W'(1);
        end
      end
      if (cmd.take_match) begin
        remain_r <= LEN_W'(in_length_code) + LEN_W'(MIN_LEN);
      end else if (issue) begin
        remain_r <= remain_r - LEN_W'(1);
      end
      if (issue) begin
        bv_r <= 1'b1;
      end else if (consume) begin
        bv_r <= 1'b0;
      end
      if (consume) begin
        if (pack_emit) begin
          fill_r <= '0;
          word_r <= '0;
        end else begin
          fill_r <= fill_r + COUNT_W'(1);
          word_r <= pack_word;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_lit) begin
      out_data_r  <= DATA_W'(in_literal_byte);
      out_count_r <= COUNT_W'(1);
      out_last_r  <= 1'b1;
      out_bad_r   <= 1'b0;
    end else if (cmd.take_bad) begin
      out_data_r  <= '0;
      out_count_r <= '0;
      out_last_r  <= 1'b1;
      out_bad_r   <= 1'b1;
    end else if (consume && pack_emit) begin
      out_data_r  <= pack_word;
      out_count_r <= fill_r + COUNT_W'(1);
      out_last_r  <= blast_r;
      out_bad_r   <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data_bytes   = out_data_r;
  assign out_byte_count   = out_count_r;
  assign out_last         = out_last_r;
  assign out_bad_distance = out_bad_r;

endmodule : lzd_datapath
`default_nettype wire

// File: rtl/lz77_token_decoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lz77_token_decoder_core: lzss token decoder with a 64 KiB history window
// input channel: one token per beat (literal, or length code and distance)
// output channel: up to eight decoded bytes per beat, first byte in bits 7:0,
//   with a byte count, a last mark on the final beat of each token and an
//   error flag for a distance of zero or beyond the bytes produced so far
// a literal or error beat is registered and shows in the cycle after the token is taken
// copies: a match of length len (3 to 258) reads one byte per cycle, while
//   the output is not stalled, from the single read port of the history ram
//   through a registered read stage; the next token is taken only after the
//   last copy byte is packed
// overlapping copies work: a byte written in the cycle it is read is
//   forwarded around the ram
// stall: when the output beat is not taken, no token is taken and the copy
//   pipeline freezes once its next beat is full; nothing is lost or repeated
// reset: rst_n (synchronous, active low) clears the write pointer, the
//   produced count and all control; history needs no clearing pass since
//   only written entries can be reached
// ----------------------------------------------------------------------------
module lz77_token_decoder_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // token beat
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_is_match,
  input  wire logic [7:0]                     in_literal_byte,
  input  wire logic [lzd_pkg::LCODE_W-1:0]    in_length_code,
  input  wire logic [lzd_pkg::DIST_W-1:0]     in_distance,
  // byte beat
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [lzd_pkg::DATA_W-1:0]          out_data_bytes,
  output logic [lzd_pkg::COUNT_W-1:0]         out_byte_count,
  output logic                                out_last,
  output logic                                out_bad_distance
);
  import lzd_pkg::*;

  lzd_cmd_t    cmd;
  lzd_status_t status;

  // token sorting and copy sequencing
  lzd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_is_match (in_is_match),
    .status      (status),
    .in_ready    (in_ready),
    .cmd         (cmd)
  );

  // history ram, copy pointers, packing and output register
  lzd_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_literal_byte  (in_literal_byte),
    .in_length_code   (in_length_code),
    .in_distance      (in_distance),
    .cmd              (cmd),
    .status           (status),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_data_bytes   (out_data_bytes),
    .out_byte_count   (out_byte_count),
    .out_last         (out_last),
    .out_bad_distance (out_bad_distance)
  );

endmodule : lz77_token_decoder_core
`default_nettype wire

// File: rtl/lzd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzd_checker: port-level checks of the lz77 token decoder
// watches both channels and flags malformed or unstable output beats
// ----------------------------------------------------------------------------
module lzd_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           in_is_match,
  input wire logic [7:0]                     in_literal_byte,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [lzd_pkg::DATA_W-1:0]     out_data_bytes,
  input wire logic [lzd_pkg::COUNT_W-1:0]    out_byte_count,
  input wire logic                           out_last,
  input wire logic                           out_bad_distance
);
  import lzd_pkg::*;

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_bytes)
      && $stable(out_byte_count) && $stable(out_last))
    else $error("output beat changed while stalled");

  // error beat is empty and final
  a_bad_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_distance |-> out_last && (out_byte_count == '0)
      && (out_data_bytes == '0))
    else $error("malformed error beat");

  // only the final beat of a token may be short
  a_full_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_byte_count == COUNT_W'(BYTES_PER_BEAT))
    else $error("short beat before end of token");

  // data beat carries one to eight bytes
  a_count_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bad_distance |-> (out_byte_count != '0)
      && (out_byte_count <= COUNT_W'(BYTES_PER_BEAT)))
    else $error("byte count out of range");

  // a literal comes out on the next cycle as a one-byte final beat
  a_lit_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_is_match |=> out_valid && out_last
      && (out_byte_count == COUNT_W'(1))
      && (out_data_bytes[7:0] == $past(in_literal_byte)))
    else $error("literal beat missing or wrong");

endmodule : lzd_checker

bind lz77_token_decoder_core lzd_checker u_lzd_checker (.*);
`default_nettype wire
